### hdl/cfgr_pkg.sv
`default_nettype none
package cfgr_pkg;
  localparam int FRAME_BITS = 48;
  localparam int SINE_TABLE_DEPTH = 256;
  localparam int IDX_BITS = $clog2(SINE_TABLE_DEPTH);
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 48;

  typedef logic [FRAME_BITS-1:0] frame_t;
  typedef logic [15:0] gain_t;
  typedef logic [SINE_TABLE_DEPTH-1:0][16:0] sine_rom_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_START_FRAME = 3'd0,
    REG_END_FRAME   = 3'd1,
    REG_GAIN_START  = 3'd2,
    REG_GAIN_END    = 3'd3,
    REG_CURVE       = 3'd4
  } cfg_reg_t;

  // per-item control travelling beside the division
  typedef struct packed {
    logic       valid;
    logic       bypass;
    gain_t      bypass_gain;
    logic       rising;
    logic       eq_power;
    gain_t      gain_start;
    gain_t      low;
    logic [15:0] diff;
  } ctl_t;

  // ceil(2^40 / d) for the taylor divisors 6, 20, 42, 72, 110, 156, 210
  localparam logic [1:7][39:0] TAYLOR_RECIP = {
    40'(((64'd1 << 40) + 64'd5) / 64'd6),
    40'(((64'd1 << 40) + 64'd19) / 64'd20),
    40'(((64'd1 << 40) + 64'd41) / 64'd42),
    40'(((64'd1 << 40) + 64'd71) / 64'd72),
    40'(((64'd1 << 40) + 64'd109) / 64'd110),
    40'(((64'd1 << 40) + 64'd155) / 64'd156),
    40'(((64'd1 << 40) + 64'd209) / 64'd210)
  };

  // quarter-wave sine entry in Q1.16, taylor series in Q30
  function automatic logic [16:0] sine_entry(input int unsigned k);
    logic [63:0] x, x2, term, sum;
    logic [63:0] pi_q30;
    logic [63:0] num;
    logic [127:0] wide;
    pi_q30 = 64'd3373259426;
    if (k >= SINE_TABLE_DEPTH) begin
      return 17'd65536;
    end
    x = (64'(k) * pi_q30 + 64'(SINE_TABLE_DEPTH)) >> (IDX_BITS + 1);
    x2 = (x * x) >> 30;
    term = x;
    sum = x;
    for (int n = 1; n <= 7; n++) begin
      // numerator stays below 2^32, so the reciprocal product floors exactly
      num = (term * x2) >> 30;
      wide = 128'(num) * 128'(TAYLOR_RECIP[n]);
      term = wide[103:40];
      if (n[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    sum = (sum + 64'd8192) >> 14;
    return (sum > 64'd65536) ? 17'd65536 : sum[16:0];
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      rom[k] = sine_entry(k);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();
endpackage
`default_nettype wire

### hdl/cfgr_div_stage.sv
`default_nettype none
// one restoring step of the fraction division per stage
module cfgr_div_stage (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cfgr_pkg::ctl_t            ctl_in,
  input  logic [cfgr_pkg::FRAME_BITS-1:0] rem_in,
  input  logic [cfgr_pkg::FRAME_BITS-1:0] span_in,
  input  logic [15:0]               q_in,
  output cfgr_pkg::ctl_t            ctl_out,
  output logic [cfgr_pkg::FRAME_BITS-1:0] rem_out,
  output logic [cfgr_pkg::FRAME_BITS-1:0] span_out,
  output logic [15:0]               q_out
);
  import cfgr_pkg::*;

  ctl_t ctl_r;
  frame_t rem_r, span_r;
  logic [15:0] q_r;
  logic [FRAME_BITS:0] twice;
  logic ge;

  // rem < span, so 2*rem fits in one extra bit
  assign twice = {rem_in, 1'b0};
  assign ge = twice >= {1'b0, span_in};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else begin
      ctl_r.valid <= ctl_in.valid;
    end
    ctl_r.bypass <= ctl_in.bypass;
    ctl_r.bypass_gain <= ctl_in.bypass_gain;
    ctl_r.rising <= ctl_in.rising;
    ctl_r.eq_power <= ctl_in.eq_power;
    ctl_r.gain_start <= ctl_in.gain_start;
    ctl_r.low <= ctl_in.low;
    ctl_r.diff <= ctl_in.diff;
    span_r <= span_in;
    rem_r <= ge ? FRAME_BITS'(twice - {1'b0, span_in}) : twice[FRAME_BITS-1:0];
    q_r <= {q_in[14:0], ge};
  end

  assign ctl_out = ctl_r;
  assign rem_out = rem_r;
  assign span_out = span_r;
  assign q_out = q_r;
endmodule
`default_nettype wire

### hdl/cfgr_curve.sv
`default_nettype none
// turns the fraction into a gain: table lookup, interpolation, scaling
module cfgr_curve (
  input  logic           clk,
  input  logic           rst_n,
  input  cfgr_pkg::ctl_t ctl_in,
  input  logic [15:0]    t_in,
  output logic           valid_out,
  output logic [15:0]    gain_out
);
  import cfgr_pkg::*;

  // stage a: phase, table reads
  ctl_t a_ctl_r;
  logic [16:0] a_e0_r, a_e1_r;
  logic [15:0] a_frac_r, a_t_r;
  logic [16:0] phase;
  logic [IDX_BITS+16:0] pos;
  logic [IDX_BITS:0] idx;
  logic [IDX_BITS-1:0] idx_next;
  logic [16:0] rom_e0, rom_e1;
  // stage b: interpolated sine
  ctl_t b_ctl_r;
  logic [16:0] b_s_r;
  logic [15:0] b_t_r;
  logic [33:0] interp;
  // stage c: product
  ctl_t c_ctl_r;
  logic [33:0] c_prod_r;
  logic [16:0] mult_in;
  // stage d: output
  logic valid_r;
  gain_t gain_r;
  logic [15:0] delta;

  assign phase = ctl_in.rising ? {1'b0, t_in} : 17'd65536 - {1'b0, t_in};
  assign pos = (IDX_BITS + 17)'(phase) << IDX_BITS;
  assign idx = pos[IDX_BITS+16:16];
  assign idx_next = idx[IDX_BITS-1:0] + IDX_BITS'(1);

  // the entry at the full quarter wave is 1.0
  assign rom_e0 = idx[IDX_BITS] ? 17'd65536 : SINE_ROM[idx[IDX_BITS-1:0]];
  assign rom_e1 = (idx >= (IDX_BITS + 1)'(SINE_TABLE_DEPTH - 1)) ? 17'd65536 :
                  SINE_ROM[idx_next];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_ctl_r.valid <= 1'b0;
      b_ctl_r.valid <= 1'b0;
      c_ctl_r.valid <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      a_ctl_r.valid <= ctl_in.valid;
      b_ctl_r.valid <= a_ctl_r.valid;
      c_ctl_r.valid <= b_ctl_r.valid;
      valid_r <= c_ctl_r.valid;
    end
    a_ctl_r.bypass <= ctl_in.bypass;
    a_ctl_r.bypass_gain <= ctl_in.bypass_gain;
    a_ctl_r.rising <= ctl_in.rising;
    a_ctl_r.eq_power <= ctl_in.eq_power;
    a_ctl_r.gain_start <= ctl_in.gain_start;
    a_ctl_r.low <= ctl_in.low;
    a_ctl_r.diff <= ctl_in.diff;
    a_e0_r <= rom_e0;
    a_e1_r <= rom_e1;
    a_frac_r <= pos[15:0];
    a_t_r <= t_in;

    b_ctl_r[$bits(ctl_t)-2:0] <= a_ctl_r[$bits(ctl_t)-2:0];
    b_s_r <= a_e0_r + 17'(interp >> 16);
    b_t_r <= a_t_r;

    c_ctl_r[$bits(ctl_t)-2:0] <= b_ctl_r[$bits(ctl_t)-2:0];
    c_prod_r <= 34'(b_ctl_r.diff) * 34'(mult_in) + 34'd32768;

    gain_r <= c_ctl_r.bypass ? c_ctl_r.bypass_gain :
              !c_ctl_r.eq_power ?
                (c_ctl_r.rising ? c_ctl_r.gain_start + delta
                                : c_ctl_r.gain_start - delta) :
              c_ctl_r.low + delta;
  end

  // table is monotonic so e1 - e0 never wraps
  assign interp = 34'(a_e1_r - a_e0_r) * 34'(a_frac_r) + 34'd32768;
  assign mult_in = b_ctl_r.eq_power ? b_s_r : {1'b0, b_t_r};
  assign delta = c_prod_r[31:16];

  assign valid_out = valid_r;
  assign gain_out = gain_r;
endmodule
`default_nettype wire

### hdl/crossfade_gain_ramp.sv
`default_nettype none
// channel   ports                                       timing
// input     start, busy, in_frame_number                 item taken on start && !busy
// result    out_valid, out_gain_value                    one cycle strobe
// config    cfg_we, cfg_index, cfg_data                  written on cfg_we
//
// one item per clock
// the pipeline is one entry stage, 16 division stages and four curve stages
// busy is always low; the receiver cannot stall, so nothing backs up
// synchronous reset clears the config registers to zero and empties the pipeline
module crossfade_gain_ramp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [cfgr_pkg::FRAME_BITS-1:0]  in_frame_number,
  output logic                             out_valid,
  output logic [15:0]                      out_gain_value,
  input  logic                             cfg_we,
  input  logic [cfgr_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [cfgr_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import cfgr_pkg::*;

  frame_t start_frame_r, end_frame_r;
  gain_t gain_start_r, gain_end_r;
  logic curve_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_frame_r <= '0;
      end_frame_r <= '0;
      gain_start_r <= '0;
      gain_end_r <= '0;
      curve_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_FRAME: start_frame_r <= cfg_data[FRAME_BITS-1:0];
        REG_END_FRAME:   end_frame_r <= cfg_data[FRAME_BITS-1:0];
        REG_GAIN_START:  gain_start_r <= cfg_data[15:0];
        REG_GAIN_END:    gain_end_r <= cfg_data[15:0];
        REG_CURVE:       curve_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // entry stage: classify and form distance and span
  ctl_t e_ctl_r;
  frame_t e_rem_r, e_span_r;
  logic rising, past, early;

  assign rising = gain_end_r >= gain_start_r;
  assign past = (end_frame_r <= start_frame_r) || (in_frame_number >= end_frame_r);
  assign early = in_frame_number <= start_frame_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_ctl_r.valid <= 1'b0;
    end else begin
      e_ctl_r.valid <= start;
    end
    e_ctl_r.bypass <= past || early;
    e_ctl_r.bypass_gain <= past ? gain_end_r : gain_start_r;
    e_ctl_r.rising <= rising;
    e_ctl_r.eq_power <= curve_r;
    e_ctl_r.gain_start <= gain_start_r;
    e_ctl_r.low <= rising ? gain_start_r : gain_end_r;
    e_ctl_r.diff <= rising ? gain_end_r - gain_start_r : gain_start_r - gain_end_r;
    // bypassed items divide 0 by 1 so the chain stays well behaved
    e_rem_r <= (past || early) ? '0 : in_frame_number - start_frame_r;
    e_span_r <= (past || early) ? FRAME_BITS'(1) : end_frame_r - start_frame_r;
  end

  ctl_t chain_ctl [17];
  frame_t chain_rem [17];
  frame_t chain_span [17];
  logic [15:0] chain_q [17];

  assign chain_ctl[0] = e_ctl_r;
  assign chain_rem[0] = e_rem_r;
  assign chain_span[0] = e_span_r;
  assign chain_q[0] = '0;

  for (genvar g = 0; g < 16; g++) begin : g_div
    cfgr_div_stage u_stage (
      .clk(clk), .rst_n(rst_n),
      .ctl_in(chain_ctl[g]), .rem_in(chain_rem[g]),
      .span_in(chain_span[g]), .q_in(chain_q[g]),
      .ctl_out(chain_ctl[g+1]), .rem_out(chain_rem[g+1]),
      .span_out(chain_span[g+1]), .q_out(chain_q[g+1])
    );
  end

  cfgr_curve u_curve (
    .clk(clk), .rst_n(rst_n),
    .ctl_in(chain_ctl[16]), .t_in(chain_q[16]),
    .valid_out(out_valid), .gain_out(out_gain_value)
  );
endmodule
`default_nettype wire

### hdl/cfgr_checker.sv
`default_nettype none
module cfgr_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);
  // every item yields exactly one result
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##21 out_valid) else $error("result missing");
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 21)) else $error("result without item");
  a_never_busy: assert property (@(posedge clk) busy == 1'b0)
    else $error("busy raised");
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result right after reset");
endmodule

bind crossfade_gain_ramp cfgr_checker u_cfgr_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid)
);
`default_nettype wire

### tb/sv/crossfade_gain_ramp_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module crossfade_gain_ramp_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic                               busy,
  input  logic [cfgr_pkg::FRAME_BITS-1:0]    in_frame_number,
  input  logic                               out_valid,
  input  logic [15:0]                        out_gain_value,
  input  logic                               cfg_we,
  input  logic [cfgr_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [cfgr_pkg::CFG_DATA_BITS-1:0] cfg_data,
  output int                                 fail_count,
  output int                                 gains_pending
);
  import cfgr_pkg::*;

  frame_t     ramp_first;
  frame_t     ramp_last;
  gain_t      level_start;
  gain_t      level_end;
  logic       eq_curve;
  logic [16:0] sine_rom [0:SINE_TABLE_DEPTH];
  gain_t      gain_queue [$];

  initial begin
    logic [63:0] x, x2, term, acc;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      if (k == SINE_TABLE_DEPTH) begin
        sine_rom[k] = 17'd65536;
      end else begin
        x = (64'(k) * 64'd3373259426 + 64'(SINE_TABLE_DEPTH)) / 64'(2 * SINE_TABLE_DEPTH);
        x2 = (x * x) >> 30;
        term = x;
        acc = x;
        for (int n = 1; n <= 7; n++) begin
          term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
          acc = (n % 2 == 1) ? acc - term : acc + term;
        end
        acc = (acc + 64'd8192) >> 14;
        sine_rom[k] = (acc > 64'd65536) ? 17'd65536 : acc[16:0];
      end
    end
  end

  // floor(65536 * d / span), d < span
  function automatic logic [15:0] ramp_position(input logic [63:0] d, input logic [63:0] span);
    logic [63:0] r;
    logic [15:0] q;
    r = d;
    q = '0;
    for (int i = 0; i < 16; i++) begin
      q = q << 1;
      if (r >= span - r) begin
        r = r - (span - r);
        q[0] = 1'b1;
      end else begin
        r = r + r;
      end
    end
    return q;
  endfunction

  function automatic logic [16:0] sine_lookup(input logic [16:0] p);
    logic [31:0] pos, idx, frac;
    logic [63:0] step;
    pos = 32'(p) * SINE_TABLE_DEPTH;
    idx = pos >> 16;
    frac = pos & 32'hFFFF;
    if (idx >= SINE_TABLE_DEPTH) begin
      return sine_rom[SINE_TABLE_DEPTH];
    end
    step = (64'(sine_rom[idx + 1] - sine_rom[idx]) * frac + 64'd32768) >> 16;
    return sine_rom[idx] + step[16:0];
  endfunction

  function automatic gain_t fade_gain(input frame_t frame);
    logic        rising;
    logic [15:0] t;
    gain_t       lo, hi;
    logic [63:0] prod;
    rising = level_end >= level_start;
    if (ramp_last <= ramp_first || frame >= ramp_last) begin
      return level_end;
    end
    if (frame <= ramp_first) begin
      return level_start;
    end
    t = ramp_position(64'(frame - ramp_first), 64'(ramp_last - ramp_first));
    lo = rising ? level_start : level_end;
    hi = rising ? level_end : level_start;
    if (!eq_curve) begin
      prod = (64'(hi - lo) * 64'(t) + 64'd32768) >> 16;
      return rising ? level_start + prod[15:0] : level_start - prod[15:0];
    end
    prod = (64'(hi - lo) * 64'(sine_lookup(rising ? 17'(t) : 17'd65536 - 17'(t))) +
            64'd32768) >> 16;
    return lo + prod[15:0];
  endfunction

  assign gains_pending = gain_queue.size();

  always @(posedge clk) begin
    gain_t want;
    if (!rst_n) begin
      ramp_first <= '0;
      ramp_last <= '0;
      level_start <= '0;
      level_end <= '0;
      eq_curve <= 1'b0;
      fail_count <= 0;
    end else begin
      if (out_valid) begin
        if (gain_queue.size() == 0) begin
          $error("gain_value: unexpected result, actual %h", out_gain_value);
          fail_count <= fail_count + 1;
        end else begin
          want = gain_queue.pop_front();
          if (out_gain_value !== want) begin
            $error("gain_value: expected %h, actual %h", want, out_gain_value);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) begin
        gain_queue.push_back(fade_gain(in_frame_number));
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_START_FRAME: ramp_first <= cfg_data;
          REG_END_FRAME:   ramp_last <= cfg_data;
          REG_GAIN_START:  level_start <= cfg_data[15:0];
          REG_GAIN_END:    level_end <= cfg_data[15:0];
          REG_CURVE:       eq_curve <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end
endmodule
`default_nettype wire

### tb/sv/crossfade_gain_ramp_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module crossfade_gain_ramp_tb;
  import cfgr_pkg::*;

  logic                      clk;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  frame_t                    in_frame_number = '0;
  logic                      out_valid;
  logic [15:0]               out_gain_value;
  logic                      cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]   cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
  int                        fail_count;
  int                        gains_pending;
  frame_t                    fade_from, fade_to;

  crossfade_gain_ramp i_dut (.*);
  crossfade_gain_ramp_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("crossfade_gain_ramp: mismatch");
    $finish;
  end

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [47:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // drain, then allow for the pipeline before touching registers
  task automatic set_fade(input frame_t a, input frame_t b, input gain_t ga, input gain_t gb,
                          input logic ep);
    start <= 1'b0;
    while (gains_pending != 0) @(posedge clk);
    repeat (25) @(posedge clk);
    write_reg(REG_START_FRAME, a);
    write_reg(REG_END_FRAME, b);
    write_reg(REG_GAIN_START, 48'(ga));
    write_reg(REG_GAIN_END, 48'(gb));
    write_reg(REG_CURVE, 48'(ep));
    // an index past the list is ignored
    write_reg(CFG_IDX_BITS'(REG_CURVE + $urandom_range(1, 3)), 48'($urandom));
    fade_from = a;
    fade_to = b;
  endtask

  // start stays high when no gap follows, so items go back to back
  task automatic send_frame(input frame_t f);
    int gap;
    start <= 1'b1;
    in_frame_number <= f;
    do @(posedge clk); while (busy);
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic frame_t pick_frame();
    frame_t span;
    span = fade_to - fade_from;
    unique case ($urandom_range(0, 9))
      0: return 48'({$urandom, $urandom});
      1: return fade_from;
      2: return fade_to;
      3: return fade_from + 48'($urandom_range(0, 2));
      4: return fade_to - 48'($urandom_range(0, 2));
      default: begin
        if (fade_to > fade_from)
          return fade_from + 48'(({$urandom, $urandom} & 48'hFFFF_FFFF_FFFF) % span);
        return 48'({$urandom, $urandom});
      end
    endcase
  endfunction

  initial begin
    frame_t a, b;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    // reset values: empty ramp
    send_frame('0);
    send_frame('1);
    // directed: linear rise, full gain range
    set_fade(48'd100, 48'd1100, 16'h0000, 16'hFFFF, 1'b0);
    send_frame(48'd0); send_frame(48'd100); send_frame(48'd101); send_frame(48'd600);
    send_frame(48'd1099); send_frame(48'd1100); send_frame('1);
    // equal-power fall
    set_fade(48'd0, '1, 16'hFFFF, 16'h0000, 1'b1);
    send_frame(48'd1); send_frame(48'h7FFF_FFFF_FFFF); send_frame('1 - 48'd1);
    send_frame(48'hAAAA_AAAA_AAAA); send_frame(48'h5555_5555_5555);
    // equal-power rise, linear fall
    set_fade(48'd10, 48'd20, 16'h1234, 16'hFEDC, 1'b1);
    for (int i = 9; i <= 21; i += 3) send_frame(48'(i));
    set_fade(48'd10, 48'd20, 16'hFEDC, 16'h1234, 1'b0);
    send_frame(48'd15);
    // empty ramp, end below start
    set_fade(48'd500, 48'd400, 16'h4000, 16'h2000, 1'b1);
    send_frame(48'd450); send_frame(48'd0);
    // random fades
    for (int ph = 0; ph < 22; ph++) begin
      a = 48'({$urandom, $urandom});
      b = (ph % 4 == 0) ? 48'({$urandom, $urandom}) :
                          a + 48'($urandom_range(1, 1 << (ph % 24)));
      if (ph % 7 == 6) b = a;
      set_fade(a, b, 16'($urandom), 16'($urandom), 1'($urandom));
      for (int i = 0; i < 25; i++) send_frame(pick_frame());
    end
    start <= 1'b0;
    while (gains_pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (fail_count == 0) begin
      $display("crossfade_gain_ramp: match");
    end else begin
      $display("crossfade_gain_ramp: mismatch");
    end
    $finish;
  end
endmodule
`default_nettype wire

### files.f
hdl/cfgr_pkg.sv
hdl/cfgr_div_stage.sv
hdl/cfgr_curve.sv
hdl/crossfade_gain_ramp.sv
hdl/cfgr_checker.sv
tb/sv/crossfade_gain_ramp_checker.sv
tb/sv/crossfade_gain_ramp_tb.sv
